### rtl/core/orb_pkg.sv
`timescale 1ns / 1ps

package orb_pkg;

    localparam int CFG_W     = 10;
    localparam int COORD_W   = 10;
    localparam int ARITH_W   = COORD_W + 2;
    localparam int MAX_SIDE  = 512;
    localparam int MAP_RESET = 512;
    localparam int TILE_W    = 16;
    localparam int TILE_BITS = 16;
    // Number of tile bits that take part in the nonzero test.
    localparam int TILE_CHK  = (TILE_BITS < TILE_W) ? TILE_BITS : TILE_W;
    localparam int ADDR_W    = 2;

    localparam logic [ADDR_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MIN_WIDTH  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MIN_HEIGHT = 2'd3;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } bounds_t;

    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } span_t;

    function automatic coord_t clamp_side(input coord_t v, input logic floor_one);
        coord_t r;
        r = v;
        if (floor_one && v == '0) begin
            r = coord_t'(1);
        end else if (int'(v) > MAX_SIDE) begin
            r = coord_t'(MAX_SIDE);
        end
        return r;
    endfunction

    // Widen one axis to the wanted size and clamp it to the map. The low end
    // may wrap below zero to a large value when the wanted size exceeds the map.
    function automatic span_t fit_axis(input coord_t mn, input coord_t mx,
                                       input coord_t side, input coord_t want);
        logic signed [ARITH_W-1:0] lo;
        logic signed [ARITH_W-1:0] hi;
        logic signed [ARITH_W-1:0] rest;
        logic signed [ARITH_W-1:0] half;
        logic signed [ARITH_W-1:0] want_s;
        logic signed [ARITH_W-1:0] side_s;
        span_t r;
        want_s = $signed({2'b00, want});
        side_s = $signed({2'b00, side});
        lo     = $signed({2'b00, mn});
        hi     = $signed({2'b00, mx}) + ARITH_W'(1);
        rest   = want_s - (hi - lo);
        if (rest < 0) begin
            rest = '0;
        end
        half = rest >>> 1;
        lo   = lo - (rest - half);
        hi   = hi + half;
        if (lo < 0) begin
            lo = '0;
            hi = want_s;
        end
        if (hi > side_s) begin
            lo = side_s - want_s;
            hi = side_s;
        end
        r.lo = lo[COORD_W-1:0];
        r.hi = hi[COORD_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/occupied_region_bounds.sv
`timescale 1ns / 1ps
// Throughput: one tile transfer per cycle while the result side keeps up.
// Pipeline: the final bounds are latched when the last tile is taken, and the
// result register then takes both axes as widened and clamped.
// Reset (aresetn low, synchronous) restores the map size registers to 512, the
// minimum sizes to 0, and starts a fresh scan with both pipeline stages empty.
module occupied_region_bounds (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [orb_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [orb_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [orb_pkg::TILE_W-1:0]   s_tdata,   // [15:0] tile_value
    input  logic                         s_tlast,   // last_tile
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [4*orb_pkg::COORD_W-1:0] m_tdata,  // low_x, low_y, high_x, high_y
    output logic                         m_tuser    // region_empty
);
    import orb_pkg::*;

    coord_t  map_width_reg, map_height_reg, min_width_reg, min_height_reg;
    coord_t  w_eff, h_eff, minw_eff, minh_eff;
    logic    out_free;
    logic    p1_valid;
    bounds_t p1_bounds;
    logic    box_empty;
    span_t   fit_x, fit_y;
    logic    m_tvalid_reg;
    logic [4*COORD_W-1:0] m_tdata_reg, m_tdata_next;
    logic    m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= coord_t'(MAP_RESET);
            map_height_reg <= coord_t'(MAP_RESET);
            min_width_reg  <= '0;
            min_height_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                REG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
                REG_MIN_WIDTH:  min_width_reg  <= cfg_wdata;
                REG_MIN_HEIGHT: min_height_reg <= cfg_wdata;
            endcase
        end
    end

    assign w_eff    = clamp_side(map_width_reg, 1'b1);
    assign h_eff    = clamp_side(map_height_reg, 1'b1);
    assign minw_eff = clamp_side(min_width_reg, 1'b0);
    assign minh_eff = clamp_side(min_height_reg, 1'b0);

    assign out_free = !m_tvalid_reg || m_tready;

    orb_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_tile   (s_tdata),
        .in_last   (s_tlast),
        .out_free  (out_free),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .in_ready  (s_tready),
        .p1_valid  (p1_valid),
        .p1_bounds (p1_bounds)
    );

    assign box_empty = (p1_bounds.min_x > p1_bounds.max_x) ||
                       (p1_bounds.min_y > p1_bounds.max_y);
    assign fit_x = fit_axis(p1_bounds.min_x, p1_bounds.max_x, w_eff, minw_eff);
    assign fit_y = fit_axis(p1_bounds.min_y, p1_bounds.max_y, h_eff, minh_eff);

    always_comb begin
        if (box_empty) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {fit_y.hi, fit_x.hi, fit_y.lo, fit_x.lo};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= p1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p1_valid) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= box_empty;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty region carries nonzero coordinates");

    a_high_x_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[3*COORD_W-1:2*COORD_W] <= w_eff)
        else $error("right edge beyond map width");

    a_high_y_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[4*COORD_W-1:3*COORD_W] <= h_eff)
        else $error("bottom edge beyond map height");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid && out_free |=> m_tvalid)
        else $error("latched bounds did not reach the result register");
`endif

endmodule

### rtl/core/orb_tracker.sv
`timescale 1ns / 1ps

module orb_tracker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [orb_pkg::TILE_W-1:0] in_tile,
    input  logic                     in_last,
    input  logic                     out_free,
    input  orb_pkg::coord_t          w_eff,
    input  orb_pkg::coord_t          h_eff,
    output logic                     in_ready,
    output logic                     p1_valid,
    output orb_pkg::bounds_t         p1_bounds
);
    import orb_pkg::*;

    coord_t  col_reg, col_next;
    coord_t  row_reg, row_next;
    bounds_t seen_reg, seen_next;
    bounds_t upd;
    logic    p1_valid_reg, p1_valid_next;
    bounds_t p1_bounds_reg;
    logic    fire;
    logic    nonzero;
    logic [COORD_W:0] col_inc;
    logic [COORD_W:0] row_inc;

    assign in_ready = !p1_valid_reg || out_free;
    assign fire     = in_valid && in_ready;
    assign nonzero  = |in_tile[TILE_CHK-1:0];
    assign col_inc  = {1'b0, col_reg} + (COORD_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (COORD_W+1)'(1);

    always_comb begin
        upd = seen_reg;
        if (nonzero) begin
            if (col_reg < seen_reg.min_x) upd.min_x = col_reg;
            if (row_reg < seen_reg.min_y) upd.min_y = row_reg;
            if (col_reg > seen_reg.max_x) upd.max_x = col_reg;
            if (row_reg > seen_reg.max_y) upd.max_y = row_reg;
        end

        col_next      = col_reg;
        row_next      = row_reg;
        seen_next     = seen_reg;
        p1_valid_next = p1_valid_reg && !out_free;

        if (fire) begin
            if (in_last) begin
                p1_valid_next   = 1'b1;
                col_next        = '0;
                row_next        = '0;
                seen_next.min_x = w_eff;
                seen_next.min_y = h_eff;
                seen_next.max_x = '0;
                seen_next.max_y = '0;
            end else begin
                seen_next = upd;
                if (col_inc >= {1'b0, w_eff}) begin
                    col_next = '0;
                    // The row wraps to zero at the map height.
                    if (row_inc >= {1'b0, h_eff}) begin
                        row_next = '0;
                    end else begin
                        row_next = row_inc[COORD_W-1:0];
                    end
                end else begin
                    col_next = col_inc[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            seen_reg.min_x <= clamp_side(coord_t'(MAP_RESET), 1'b1);
            seen_reg.min_y <= clamp_side(coord_t'(MAP_RESET), 1'b1);
            seen_reg.max_x <= '0;
            seen_reg.max_y <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            seen_reg     <= seen_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last) begin
            p1_bounds_reg <= upd;
        end
    end

    assign p1_valid  = p1_valid_reg;
    assign p1_bounds = p1_bounds_reg;

endmodule
